FILE: src/sacl_pkg.sv
package sacl_pkg;

	// Cache geometry
	localparam int NUM_SETS    = 64;
	localparam int NUM_WAYS    = 4;
	localparam int BLOCK_BYTES = 32;

	localparam int ADDR_W     = 32;
	localparam int BYTE_OFS_W = 2;
	localparam int CNT_W      = 32;
	localparam int WAY_OUT_W  = 2;

	// Floor of log2, evaluated at elaboration only
	function automatic int floor_log2(input int v);
		int n;
		int x;
		n = 0;
		x = v;
		while (x > 1) begin
			x = x >> 1;
			n = n + 1;
		end
		return n;
	endfunction

	localparam int OFS_W  = floor_log2(BLOCK_BYTES / 4);
	localparam int IDX_W  = floor_log2(NUM_SETS);
	localparam int IDX_LO = BYTE_OFS_W + OFS_W;
	localparam int TAG_LO = IDX_LO + IDX_W;
	localparam int TAG_W  = ADDR_W - TAG_LO;

	// Index widths that stay legal for a single set or a single way
	localparam int SET_AW    = (IDX_W > 0) ? IDX_W : 1;
	localparam int ROWS      = 1 << IDX_W;
	localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	// Stream payload widths
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_FIELD_W = WAY_OUT_W + 2 * CNT_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// One way of a set: valid, tag and LRU rank (0 is least recently used)
	typedef struct packed {
		logic             vld;
		logic [TAG_W-1:0] tag;
		logic [WAY_W-1:0] rank;
	} way_ent_t;

	typedef way_ent_t [NUM_WAYS-1:0] set_row_t;

	// Row contents after reset: nothing valid, tag zero, rank equals way number
	function automatic set_row_t reset_row();
		set_row_t r;
		for (int w = 0; w < NUM_WAYS; w++) begin
			r[w].vld  = 1'b0;
			r[w].tag  = '0;
			r[w].rank = WAY_W'(w);
		end
		return r;
	endfunction

endpackage

FILE: src/set_assoc_cache_lru_lookup_unit.sv
// Tag-only set-associative cache lookup with true LRU replacement
// (sacl_pkg::NUM_SETS sets of sacl_pkg::NUM_WAYS ways, sacl_pkg::BLOCK_BYTES
// bytes a block). Each input transaction on s_* carries one 32-bit byte
// address; each produces exactly one result transaction on m_*, in order,
// with m_tuser = hit and m_tdata holding the way used and the running hit
// and miss totals. One address is taken every clock cycle unless m_tready
// holds results back. Each result passes the lookup stage registers and the
// result registers: the set row is read from the tag memory (one read and one
// write port, one row per set) at the accepting edge, then the lookup stage
// compares, chooses the way, ages the ranks and registers the result.
// Back-to-back accesses to the same set are forwarded, so no bubble is needed.
// Back-pressure on m_tready stalls the lookup stage in place.
// No clearing pass is needed after reset: a per-set written flag makes a
// never-touched set read as its reset contents.
module set_assoc_cache_lru_lookup_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sacl_pkg::IN_TDATA_W-1:0]   s_tdata,  // [31:0] address
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sacl_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [1:0] way_used, [33:2] hit_total,
	                                                    // [65:34] miss_total, rest zero
	output logic                              m_tuser   // [0] hit
);

	// Tag memory, one row per set
	sacl_pkg::set_row_t tag_mem [sacl_pkg::ROWS];
	logic [sacl_pkg::ROWS-1:0] written_q;

	// Lookup stage registers
	logic                           vld_s1;
	logic [sacl_pkg::TAG_W-1:0]     tag_s1;
	logic [sacl_pkg::SET_AW-1:0]    idx_s1;
	sacl_pkg::set_row_t             mem_rd_s1;
	sacl_pkg::set_row_t             fwd_row_s1;
	logic                           fwd_s1;
	logic                           written_s1;

	// Result registers
	logic                           out_vld_q;
	logic                           hit_q;
	logic [sacl_pkg::WAY_OUT_W-1:0] way_q;
	logic [sacl_pkg::CNT_W-1:0]     hit_cnt_q;
	logic [sacl_pkg::CNT_W-1:0]     miss_cnt_q;

	logic                           s_hs;
	logic                           adv;
	logic [sacl_pkg::TAG_W-1:0]     tag_in;
	logic [sacl_pkg::SET_AW-1:0]    idx_in;
	sacl_pkg::set_row_t             row;
	sacl_pkg::set_row_t             new_row;
	logic                           hit;
	logic [sacl_pkg::WAY_W-1:0]     hit_way;
	logic [sacl_pkg::WAY_W-1:0]     victim;
	logic [sacl_pkg::WAY_W-1:0]     way_sel;
	logic [sacl_pkg::WAY_W-1:0]     old_rank;

	// Split the incoming address
	assign tag_in = s_tdata[sacl_pkg::ADDR_W-1:sacl_pkg::TAG_LO];
	generate
		if (sacl_pkg::IDX_W > 0) begin : g_idx
			assign idx_in = s_tdata[sacl_pkg::IDX_LO +: sacl_pkg::SET_AW];
		end else begin : g_noidx
			assign idx_in = '0;
		end
	endgenerate

	// Handshake: the lookup stage moves when the result register is empty or being taken
	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign s_hs     = s_tvalid && s_tready;

	// Pick the current set contents: forwarded, stored or reset value
	always_comb begin
		if (fwd_s1) begin
			row = fwd_row_s1;
		end else if (written_s1) begin
			row = mem_rd_s1;
		end else begin
			row = sacl_pkg::reset_row();
		end
	end

	// Compare tags, pick the way and age the ranks
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		victim  = '0;
		for (int w = sacl_pkg::NUM_WAYS - 1; w >= 0; w--) begin
			if (row[w].vld && row[w].tag == tag_s1) begin
				hit     = 1'b1;
				hit_way = sacl_pkg::WAY_W'(w);
			end
			if (row[w].rank == '0) begin
				victim = sacl_pkg::WAY_W'(w);
			end
		end
		way_sel  = hit ? hit_way : victim;
		old_rank = row[way_sel].rank;
		new_row  = row;
		for (int w = 0; w < sacl_pkg::NUM_WAYS; w++) begin
			if (sacl_pkg::WAY_W'(w) == way_sel) begin
				if (!hit) begin
					new_row[w].vld = 1'b1;
					new_row[w].tag = tag_s1;
				end
				new_row[w].rank = sacl_pkg::WAY_W'(sacl_pkg::NUM_WAYS - 1);
			end else if (row[w].rank > old_rank) begin
				new_row[w].rank = row[w].rank - 1'b1;
			end
		end
	end

	// Write back the updated row, read the row for the next transaction
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_mem[idx_s1] <= new_row;
		end
		if (s_hs) begin
			mem_rd_s1 <= tag_mem[idx_in];
		end
	end

	// Lookup stage payload, with bypass of a row written in the same cycle
	always_ff @(posedge clk) begin
		if (s_hs) begin
			tag_s1     <= tag_in;
			idx_s1     <= idx_in;
			fwd_row_s1 <= new_row;
			fwd_s1     <= adv && (idx_s1 == idx_in);
			written_s1 <= written_q[idx_in];
		end
	end

	// Control: stage valid, set written flags, result valid, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			written_q  <= '0;
			out_vld_q  <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			if (s_hs) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				written_q[idx_s1] <= 1'b1;
				out_vld_q         <= 1'b1;
				if (hit) begin
					hit_cnt_q <= hit_cnt_q + 1'b1;
				end else begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Hold the result fields
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= hit;
			way_q <= sacl_pkg::WAY_OUT_W'(way_sel);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {
		(sacl_pkg::OUT_TDATA_W - sacl_pkg::OUT_FIELD_W)'(0),
		miss_cnt_q,
		hit_cnt_q,
		way_q
	};

endmodule

FILE: src/sacl_checker.sv
module sacl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [sacl_pkg::IN_TDATA_W-1:0]   s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sacl_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                              m_tuser
);

	logic                       in_hs;
	logic                       out_hs;
	logic [2:0]                 pend_q;
	logic                       seen_q;
	logic [sacl_pkg::CNT_W-1:0] prev_hit_q;
	logic [sacl_pkg::CNT_W-1:0] prev_miss_q;
	logic [sacl_pkg::CNT_W-1:0] hit_tot;
	logic [sacl_pkg::CNT_W-1:0] miss_tot;

	assign in_hs    = s_tvalid && s_tready;
	assign out_hs   = m_tvalid && m_tready;
	assign hit_tot  = m_tdata[sacl_pkg::WAY_OUT_W +: sacl_pkg::CNT_W];
	assign miss_tot = m_tdata[sacl_pkg::WAY_OUT_W + sacl_pkg::CNT_W +: sacl_pkg::CNT_W];

	// Track transactions in flight and the totals of the last result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			seen_q      <= 1'b0;
			prev_hit_q  <= '0;
			prev_miss_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b0, in_hs} - {2'b0, out_hs};
			if (out_hs) begin
				seen_q      <= 1'b1;
				prev_hit_q  <= hit_tot;
				prev_miss_q <= miss_tot;
			end
		end
	end

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// No result without an accepted address
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("result without a pending transaction");

	// At most two transactions in flight
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("too many transactions in flight");

	// Totals step by exactly one, matching the hit flag; the first result must be a miss
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs |->
			hit_tot == prev_hit_q + {31'b0, m_tuser} &&
			miss_tot == prev_miss_q + {31'b0, !m_tuser} &&
			(seen_q || !m_tuser))
		else $error("hit or miss total out of step");

endmodule

bind set_assoc_cache_lru_lookup_unit sacl_checker u_sacl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 410;
	localparam int HOT_SETS = 4;
	localparam int HOT_TAGS = 6;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [sacl_pkg::IN_TDATA_W-1:0]  s_tdata;   // [31:0] address
	logic                             m_tvalid;
	logic                             m_tready;
	logic [sacl_pkg::OUT_TDATA_W-1:0] m_tdata;   // [1:0] way_used, [33:2] hit_total,
	                                             // [65:34] miss_total
	logic                             m_tuser;   // [0] hit

	// One predicted lookup outcome
	typedef struct {
		logic                           hit;
		logic [sacl_pkg::WAY_OUT_W-1:0] way;
		logic [sacl_pkg::CNT_W-1:0]     hit_total;
		logic [sacl_pkg::CNT_W-1:0]     miss_total;
	} lookup_t;

	// Tag-store shadow with true LRU ranks; predicts and checks lookups in order
	class cache_scoreboard;
		bit                         line_valid [sacl_pkg::NUM_SETS][sacl_pkg::NUM_WAYS];
		logic [sacl_pkg::TAG_W-1:0] line_tag   [sacl_pkg::NUM_SETS][sacl_pkg::NUM_WAYS];
		int unsigned                line_rank  [sacl_pkg::NUM_SETS][sacl_pkg::NUM_WAYS];
		logic [sacl_pkg::CNT_W-1:0] hit_count;
		logic [sacl_pkg::CNT_W-1:0] miss_count;
		lookup_t                    expected_lookups[$];
		int unsigned                error_count;

		function new();
			for (int s = 0; s < sacl_pkg::NUM_SETS; s++) begin
				for (int w = 0; w < sacl_pkg::NUM_WAYS; w++) begin
					line_valid[s][w] = 1'b0;
					line_tag[s][w]   = '0;
					line_rank[s][w]  = w;
				end
			end
			hit_count   = '0;
			miss_count  = '0;
			error_count = 0;
		endfunction

		// Look up one accepted address, update the shadow and queue the outcome
		function void note_address(input logic [sacl_pkg::ADDR_W-1:0] addr);
			int unsigned                set_idx;
			int unsigned                way;
			int unsigned                old_rank;
			logic [sacl_pkg::TAG_W-1:0] tag;
			bit                         hit;
			lookup_t                    res;
			set_idx = (addr >> sacl_pkg::IDX_LO) & ((1 << sacl_pkg::IDX_W) - 1);
			tag     = sacl_pkg::TAG_W'(addr >> sacl_pkg::TAG_LO);
			hit     = 1'b0;
			way     = 0;
			// scan downward so the lowest matching way wins
			for (int w = sacl_pkg::NUM_WAYS - 1; w >= 0; w--) begin
				if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
					hit = 1'b1;
					way = w;
				end
			end
			// fill the least recently used way on a miss
			if (!hit) begin
				way = 0;
				for (int w = sacl_pkg::NUM_WAYS - 1; w >= 0; w--) begin
					if (line_rank[set_idx][w] == 0)
						way = w;
				end
				line_valid[set_idx][way] = 1'b1;
				line_tag[set_idx][way]   = tag;
			end
			// age ranks above the old one, then make this way most recent
			old_rank = line_rank[set_idx][way];
			for (int w = 0; w < sacl_pkg::NUM_WAYS; w++) begin
				if (line_rank[set_idx][w] > old_rank)
					line_rank[set_idx][w]--;
			end
			line_rank[set_idx][way] = sacl_pkg::NUM_WAYS - 1;
			if (hit)
				hit_count++;
			else
				miss_count++;
			res.hit        = hit;
			res.way        = sacl_pkg::WAY_OUT_W'(way);
			res.hit_total  = hit_count;
			res.miss_total = miss_count;
			expected_lookups.push_back(res);
		endfunction

		// Compare one result transaction against the oldest prediction
		function void check_result(input logic hit,
			input logic [sacl_pkg::OUT_TDATA_W-1:0] data);
			lookup_t want;
			if (expected_lookups.size() == 0) begin
				$display("%0t: result with nothing expected: hit %0b data %h", $time, hit, data);
				error_count++;
				return;
			end
			want = expected_lookups.pop_front();
			if (hit !== want.hit) begin
				$display("%0t: hit expected %0b got %0b", $time, want.hit, hit);
				error_count++;
			end
			if (data[sacl_pkg::WAY_OUT_W-1:0] !== want.way) begin
				$display("%0t: way_used expected %0d got %0d", $time, want.way,
					data[sacl_pkg::WAY_OUT_W-1:0]);
				error_count++;
			end
			if (data[sacl_pkg::WAY_OUT_W +: sacl_pkg::CNT_W] !== want.hit_total) begin
				$display("%0t: hit_total expected %0d got %0d", $time, want.hit_total,
					data[sacl_pkg::WAY_OUT_W +: sacl_pkg::CNT_W]);
				error_count++;
			end
			if (data[sacl_pkg::WAY_OUT_W + sacl_pkg::CNT_W +: sacl_pkg::CNT_W]
				!== want.miss_total) begin
				$display("%0t: miss_total expected %0d got %0d", $time, want.miss_total,
					data[sacl_pkg::WAY_OUT_W + sacl_pkg::CNT_W +: sacl_pkg::CNT_W]);
				error_count++;
			end
		endfunction

		function int unsigned pending();
			return expected_lookups.size();
		endfunction
	endclass

	cache_scoreboard            sb;
	int unsigned                src_idle_pct;
	int unsigned                sink_idle_pct;
	logic [sacl_pkg::TAG_W-1:0] hot_tag;
	int unsigned                hot_set[HOT_SETS];

	set_assoc_cache_lru_lookup_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [sacl_pkg::ADDR_W-1:0] make_address(
		input logic [sacl_pkg::TAG_W-1:0] tag,
		input int unsigned set_idx, input int unsigned low);
		return (sacl_pkg::ADDR_W'(tag) << sacl_pkg::TAG_LO) |
			(sacl_pkg::ADDR_W'(set_idx) << sacl_pkg::IDX_LO) |
			(sacl_pkg::ADDR_W'(low) &
				((sacl_pkg::ADDR_W'(1) << sacl_pkg::IDX_LO) - 1));
	endfunction

	// Mostly a small working set of tags over a few sets, rest fully random
	function automatic logic [sacl_pkg::ADDR_W-1:0] pick_address();
		logic [sacl_pkg::TAG_W-1:0] tag;
		if ($urandom_range(99) < 70) begin
			tag = hot_tag + sacl_pkg::TAG_W'($urandom_range(HOT_TAGS - 1));
			return make_address(tag, hot_set[$urandom_range(HOT_SETS - 1)], $urandom());
		end
		return $urandom();
	endfunction

	// Drive one address and hold it until the transaction completes
	task automatic send_address(input logic [sacl_pkg::ADDR_W-1:0] addr);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = addr;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_address(addr);
		@(negedge clk);
	endtask

	// Hold off the sender until every expected result has come back
	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Receiver readiness, changed at the falling edge
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Check each result transaction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// End the run when nothing moves for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("set_assoc_cache_lru_lookup_unit verification failed");
		$finish;
	end

	initial begin
		logic [sacl_pkg::ADDR_W-1:0] directed[$];
		logic [sacl_pkg::TAG_W-1:0]  tag_a;
		logic [sacl_pkg::TAG_W-1:0]  tag_b;
		logic [sacl_pkg::TAG_W-1:0]  tag_c;
		logic [sacl_pkg::TAG_W-1:0]  tag_d;
		logic [sacl_pkg::TAG_W-1:0]  tag_e;
		sb            = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		src_idle_pct  = 10;
		sink_idle_pct = 74;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: address extremes, a full set, eviction order and middle promotion
		tag_a = sacl_pkg::TAG_W'(1);
		tag_b = sacl_pkg::TAG_W'(21'h0ABCD);
		tag_c = sacl_pkg::TAG_W'(21'h15555);
		tag_d = sacl_pkg::TAG_W'(21'h1FFFE);
		tag_e = '0;   // zero tag, held by no filled way, must still miss
		directed.push_back('0);
		directed.push_back('0);
		directed.push_back('1);
		directed.push_back(make_address('1, sacl_pkg::NUM_SETS - 1, 0));
		directed.push_back(make_address(tag_a, 5, 0));
		directed.push_back(make_address(tag_b, 5, 4));
		directed.push_back(make_address(tag_c, 5, 8));
		directed.push_back(make_address(tag_d, 5, 31));
		directed.push_back(make_address(tag_b, 5, 1));
		directed.push_back(make_address(tag_e, 5, 0));
		directed.push_back(make_address(tag_a, 5, 2));
		directed.push_back(make_address(tag_c, 5, 3));
		directed.push_back(make_address(tag_e, 5, 31));
		directed.push_back(make_address(tag_a, 5, 16));
		directed.push_back(make_address('1, 0, 31));
		directed.push_back(make_address('1, 0, 0));
		foreach (directed[i])
			send_address(directed[i]);
		drain();

		// Random phases: sender-light, receiver-light, then no idling
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 74 : 0;
			sink_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 10 : 0;
			hot_tag = sacl_pkg::TAG_W'($urandom());
			foreach (hot_set[i])
				hot_set[i] = $urandom_range(sacl_pkg::NUM_SETS - 1);
			repeat (ITEMS_PER_PHASE)
				send_address(pick_address());
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.error_count == 0 && sb.pending() == 0)
			$display("set_assoc_cache_lru_lookup_unit verification clean");
		else
			$display("set_assoc_cache_lru_lookup_unit verification failed");
		$finish;
	end

endmodule
